// ===== rtl/scip_scan_response_decoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the scan response decoder
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SCIP_SCAN_RESPONSE_DECODER_TOP_MACROS_SVH
`define SCIP_SCAN_RESPONSE_DECODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SSRD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define SSRD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define SSRD_ASSERT(lbl, clk, rstn, prop, msg)
`define SSRD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/ssrd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan response decoder package
// Result word type, result kinds, error codes and protocol characters.
// ----------------------------------------------------------------------------
package ssrd_pkg;

  localparam int IDX_W   = 11;
  localparam int VAL_W   = 24;
  localparam int KIND_W  = 2;
  localparam int TDATA_W = 40;

  localparam logic [KIND_W-1:0] KIND_DIST = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TIME = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERR  = 2'd3;

  localparam logic [VAL_W-1:0] ERR_ECHO     = 24'd0;
  localparam logic [VAL_W-1:0] ERR_MARKER   = 24'd1;
  localparam logic [VAL_W-1:0] ERR_CHECKSUM = 24'd2;

  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_M    = 8'h4d;
  localparam logic [7:0] CH_G    = 8'h47;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_B    = 8'h62;
  localparam logic [7:0] CH_ZERO = 8'h30;

  localparam logic [IDX_W-1:0] IDX_MAX = 11'h7ff;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  value;
    logic [IDX_W-1:0]  index;
    logic              last;
  } ssrd_res_t;

  function automatic logic [5:0] six(input logic [7:0] c);
    return c[5:0] - CH_ZERO[5:0];
  endfunction

endpackage

// ===== rtl/scip_scan_response_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan response decoder, top level
// Decodes a rangefinder's serial response into distance and timestamp words.
// ----------------------------------------------------------------------------
// The in_ channel takes one received character per word. A character that is
// not a line end is stored in the line memory. At a line end, or when the
// line is full, in_tready falls while the stored line is walked through the
// single read port of the line memory: a read and an accumulate step per
// stored character for the checksum pass, a decide step, and for data lines
// a read and a decode step per decoded character; in_tready stays low until
// the walk ends. The out_ channel carries distances, the timestamp, scan ends
// and errors; tlast marks the final word caused by one character. A word sits
// in one output register; while the receiver stalls, the walk pauses at the
// next word to be sent. After reset the block waits for an echo line, and
// first_step, written over the APB port, is zero.
// ----------------------------------------------------------------------------
module scip_scan_response_decoder_top #(
  parameter int LINE_MAX   = 128,
  parameter int DATA_CHARS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // rx_byte [7:0]
  input  logic [7:0]                   in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // value [23:0], index [34:24], zero [39:35]
  output logic [ssrd_pkg::TDATA_W-1:0] out_tdata,
  // kind [1:0]
  output logic [ssrd_pkg::KIND_W-1:0]  out_tuser,
  output logic                         out_tlast,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam logic REG_FIRST_STEP = 1'b0;

  logic [ssrd_pkg::IDX_W-1:0] first_step_r;
  logic                       cfg_wr;
  logic                       out_free;
  ssrd_pkg::ssrd_res_t        res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FIRST_STEP);
  assign prdata = (paddr[2] == REG_FIRST_STEP) ? 32'(first_step_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_step_r <= '0;
    end else if (cfg_wr) begin
      first_step_r <= pwdata[ssrd_pkg::IDX_W-1:0];
    end
  end

  ssrd_line_walker #(
    .LINE_MAX   (LINE_MAX),
    .DATA_CHARS (DATA_CHARS)
  ) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_byte    (in_tdata),
    .in_ready   (in_tready),
    .first_step (first_step_r),
    .out_free   (out_free),
    .res        (res)
  );

  ssrd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/ssrd_line_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan response line walker
// Stores the current line and, at a line end or a full line, walks it
// via one read port: a checksum pass, then a decode pass for data lines.
// ----------------------------------------------------------------------------
`include "scip_scan_response_decoder_top_macros.svh"

module ssrd_line_walker #(
  parameter int LINE_MAX   = 128,
  parameter int DATA_CHARS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [7:0]               in_byte,
  output logic                     in_ready,
  input  logic [ssrd_pkg::IDX_W-1:0] first_step,
  input  logic                     out_free,
  output ssrd_pkg::ssrd_res_t      res
);

  localparam int LEN_W = $clog2(LINE_MAX);
  localparam int DC_W  = $clog2(DATA_CHARS + 1);
  localparam int CNT_W = (LEN_W > DC_W) ? LEN_W : DC_W;
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(LINE_MAX - 1);
  localparam logic [CNT_W-1:0] DC_MAX   = CNT_W'(DATA_CHARS);

  localparam logic [2:0] LN_IDLE   = 3'd0;
  localparam logic [2:0] LN_STATUS = 3'd3;
  localparam logic [2:0] LN_MARKER = 3'd4;
  localparam logic [2:0] LN_TIME   = 3'd5;
  localparam logic [2:0] LN_DATA   = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_ACC,
    ST_DECIDE,
    ST_DRD,
    ST_DACC
  } state_t;

  logic [7:0] mem [LINE_MAX];
  logic [7:0] rd_data_r;

  state_t                    state_r, state_nxt;
  logic [LEN_W-1:0]          line_len_r, line_len_nxt;
  logic [LEN_W-1:0]          len_r, len_nxt;
  logic [CNT_W-1:0]          ptr_r, ptr_nxt;
  logic [CNT_W-1:0]          nd_r, nd_nxt;
  logic [5:0]                sum_r, sum_nxt;
  logic [7:0]                head_r [4];
  logic [7:0]                head_nxt [4];
  logic [7:0]                last_c_r, last_c_nxt;
  logic [2:0]                line_num_r, line_num_nxt;
  logic                      echo_g_r, echo_g_nxt;
  logic [7:0]                carry_c_r [2];
  logic [7:0]                carry_c_nxt [2];
  logic [1:0]                carry_r, carry_nxt;
  logic [ssrd_pkg::IDX_W-1:0] next_idx_r, next_idx_nxt;

  logic             acc, is_eol, wr_en, rd_en, start;
  logic [LEN_W-1:0] len_inc, start_len;
  logic [CNT_W-1:0] len_ext, len_m1, nd_calc;
  logic             chk_bad, marker, echo_ok;
  logic [ssrd_pkg::VAL_W-1:0] ts;

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    acc       = in_valid && in_ready;
    is_eol    = (in_byte == ssrd_pkg::CH_CR) || (in_byte == ssrd_pkg::CH_LF);
    wr_en     = acc && !is_eol;
    len_inc   = line_len_r + 1'b1;
    start     = acc && (is_eol || (len_inc == LEN_FULL));
    start_len = is_eol ? line_len_r : len_inc;

    len_ext = CNT_W'(len_r);
    len_m1  = len_ext - 1'b1;
    nd_calc = (len_m1 > DC_MAX) ? DC_MAX : len_m1;
    chk_bad = (line_num_r > LN_STATUS) && (len_r >= LEN_W'(3)) &&
              ((8'({2'b00, sum_r}) + ssrd_pkg::CH_ZERO) != last_c_r);
    marker  = (len_r >= LEN_W'(3)) && (head_r[0] == ssrd_pkg::CH_NINE) &&
              (head_r[1] == ssrd_pkg::CH_NINE) && (head_r[2] == ssrd_pkg::CH_B);
    echo_ok = (len_r != '0) &&
              ((head_r[0] == ssrd_pkg::CH_M) || (head_r[0] == ssrd_pkg::CH_G));
    ts = {(len_r > LEN_W'(0)) ? ssrd_pkg::six(head_r[0]) : 6'd0,
          (len_r > LEN_W'(1)) ? ssrd_pkg::six(head_r[1]) : 6'd0,
          (len_r > LEN_W'(2)) ? ssrd_pkg::six(head_r[2]) : 6'd0,
          (len_r > LEN_W'(3)) ? ssrd_pkg::six(head_r[3]) : 6'd0};
  end

  always_comb begin
    state_nxt    = state_r;
    line_len_nxt = line_len_r;
    len_nxt      = len_r;
    ptr_nxt      = ptr_r;
    nd_nxt       = nd_r;
    sum_nxt      = sum_r;
    head_nxt     = head_r;
    last_c_nxt   = last_c_r;
    line_num_nxt = line_num_r;
    echo_g_nxt   = echo_g_r;
    carry_c_nxt  = carry_c_r;
    carry_nxt    = carry_r;
    next_idx_nxt = next_idx_r;
    rd_en        = 1'b0;
    res          = '0;

    case (state_r)
      ST_IDLE: begin
        if (wr_en) begin
          line_len_nxt = len_inc;
        end
        if (start) begin
          line_len_nxt = '0;
          len_nxt      = start_len;
          ptr_nxt      = '0;
          sum_nxt      = '0;
          state_nxt    = (start_len == '0) ? ST_DECIDE : ST_RD;
        end
      end
      ST_RD: begin
        rd_en     = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (ptr_r < CNT_W'(4)) begin
          head_nxt[ptr_r[1:0]] = rd_data_r;
        end
        if (ptr_r == len_m1) begin
          last_c_nxt = rd_data_r;
          state_nxt  = ST_DECIDE;
        end else begin
          sum_nxt   = sum_r + rd_data_r[5:0];
          ptr_nxt   = ptr_r + 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
          res.index = '0;
          res.last  = 1'b1;
          if (chk_bad) begin
            res.valid    = 1'b1;
            res.kind     = ssrd_pkg::KIND_ERR;
            res.value    = ssrd_pkg::ERR_CHECKSUM;
            line_num_nxt = LN_IDLE;
            carry_nxt    = '0;
          end else if ((line_num_r >= LN_DATA) && (len_r == '0)) begin
            res.valid    = 1'b1;
            res.kind     = ssrd_pkg::KIND_END;
            res.value    = '0;
            line_num_nxt = LN_IDLE;
            carry_nxt    = '0;
          end else if (line_num_r == LN_IDLE) begin
            if (echo_ok) begin
              echo_g_nxt   = (head_r[0] == ssrd_pkg::CH_G);
              carry_nxt    = '0;
              next_idx_nxt = first_step;
              line_num_nxt = 3'd1;
            end else begin
              res.valid = 1'b1;
              res.kind  = ssrd_pkg::KIND_ERR;
              res.value = ssrd_pkg::ERR_ECHO;
            end
          end else if ((line_num_r <= LN_MARKER) && marker) begin
            line_num_nxt = LN_TIME;
          end else if ((line_num_r == 3'd1) && echo_g_r) begin
            line_num_nxt = LN_TIME;
          end else if (line_num_r == LN_MARKER) begin
            res.valid    = 1'b1;
            res.kind     = ssrd_pkg::KIND_ERR;
            res.value    = ssrd_pkg::ERR_MARKER;
            line_num_nxt = LN_IDLE;
            carry_nxt    = '0;
          end else if (line_num_r == LN_TIME) begin
            res.valid    = 1'b1;
            res.kind     = ssrd_pkg::KIND_TIME;
            res.value    = ts;
            line_num_nxt = LN_DATA;
          end else if (line_num_r >= LN_DATA) begin
            line_num_nxt = LN_DATA;
            nd_nxt       = nd_calc;
            ptr_nxt      = '0;
            if (nd_calc != '0) begin
              state_nxt = ST_DRD;
            end
          end else begin
            line_num_nxt = line_num_r + 1'b1;
          end
        end
      end
      ST_DRD: begin
        rd_en     = 1'b1;
        state_nxt = ST_DACC;
      end
      ST_DACC: begin
        if ((carry_r != 2'd2) || out_free) begin
          if (carry_r == 2'd2) begin
            res.valid = 1'b1;
            res.kind  = ssrd_pkg::KIND_DIST;
            res.value = ssrd_pkg::VAL_W'({ssrd_pkg::six(carry_c_r[0]),
                                          ssrd_pkg::six(carry_c_r[1]),
                                          ssrd_pkg::six(rd_data_r)});
            res.index = next_idx_r;
            res.last  = (({1'b0, ptr_r} + (CNT_W + 1)'(3)) >= {1'b0, nd_r});
            if (next_idx_r != ssrd_pkg::IDX_MAX) begin
              next_idx_nxt = next_idx_r + 1'b1;
            end
            carry_nxt = '0;
          end else begin
            carry_c_nxt[carry_r[0]] = rd_data_r;
            carry_nxt = carry_r + 1'b1;
          end
          ptr_nxt   = ptr_r + 1'b1;
          state_nxt = ((ptr_r + 1'b1) == nd_r) ? ST_IDLE : ST_DRD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[line_len_r] <= in_byte;
    end
    if (rd_en) begin
      rd_data_r <= mem[ptr_r[LEN_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      line_len_r <= '0;
      line_num_r <= LN_IDLE;
      echo_g_r   <= 1'b0;
      carry_r    <= '0;
      next_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      line_len_r <= line_len_nxt;
      line_num_r <= line_num_nxt;
      echo_g_r   <= echo_g_nxt;
      carry_r    <= carry_nxt;
      next_idx_r <= next_idx_nxt;
    end
    len_r     <= len_nxt;
    ptr_r     <= ptr_nxt;
    nd_r      <= nd_nxt;
    sum_r     <= sum_nxt;
    head_r    <= head_nxt;
    last_c_r  <= last_c_nxt;
    carry_c_r <= carry_c_nxt;
  end

  `SSRD_ASSERT(a_len_bound, clk, rst_n, line_len_r < LEN_FULL, "Line length reached the full mark.")
  `SSRD_ASSERT(a_carry_bound, clk, rst_n, carry_r != 2'd3, "Carry holds three characters.")
  `SSRD_ASSERT(a_line_num, clk, rst_n, line_num_r <= LN_DATA, "Line number beyond data lines.")
  `SSRD_ASSERT_IMP(a_push_free, clk, rst_n, res.valid, out_free, "Word pushed into a busy output stage.")

endmodule

// ===== rtl/ssrd_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan response output stage
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module ssrd_out_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ssrd_pkg::ssrd_res_t          push,
  output logic                         free,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // value [23:0], index [34:24], zero [39:35]
  output logic [ssrd_pkg::TDATA_W-1:0] out_tdata,
  // kind [1:0]
  output logic [ssrd_pkg::KIND_W-1:0]  out_tuser,
  output logic                         out_tlast
);

  logic                        valid_r;
  logic [ssrd_pkg::KIND_W-1:0] kind_r;
  logic [ssrd_pkg::VAL_W-1:0]  value_r;
  logic [ssrd_pkg::IDX_W-1:0]  index_r;
  logic                        last_r;

  assign free       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {(ssrd_pkg::TDATA_W - ssrd_pkg::IDX_W - ssrd_pkg::VAL_W)'(0),
                       index_r, value_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push.valid) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
    if (push.valid) begin
      kind_r  <= push.kind;
      value_r <= push.value;
      index_r <= push.index;
      last_r  <= push.last;
    end
  end

endmodule

// ===== sim/scip_scan_response_decoder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan response decoder testbench
// Sends rangefinder responses one character per word: short directed scans,
// then random well-formed scans mixed with broken ones and line noise. Every
// accepted character is run through a bit-accurate predictor, and each
// result word is compared field by field with the oldest predicted word.
// ----------------------------------------------------------------------------
module scip_scan_response_decoder_top_tb;
  import ssrd_pkg::*;

  localparam int         LINE_CAP       = 128;
  localparam int         DATA_LIMIT     = 64;
  localparam logic [2:0] REG_FIRST_STEP = 3'd0;
  localparam int         SETTLE_CYCLES  = 600;
  localparam int         HOLD_CYCLES    = 800;
  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         RANDOM_BYTES   = 40;

  typedef enum int {FAULT_NONE, FAULT_ECHO, FAULT_MARKER, FAULT_SUM} fault_t;
  typedef logic [7:0] char_q_t[$];

  class scan_scoreboard;
    typedef struct {
      logic [KIND_W-1:0] kind;
      logic [VAL_W-1:0]  value;
      logic [IDX_W-1:0]  index;
      logic              last;
    } word_t;

    word_t            expected_words[$];
    logic [7:0]       line_buf[LINE_CAP];
    logic [7:0]       carry_buf[2];
    int unsigned      line_len = 0;
    int unsigned      line_no = 0;
    int unsigned      carry_n = 0;
    bit               echo_g = 1'b0;
    logic [IDX_W-1:0] first_step = '0;
    logic [IDX_W-1:0] next_idx = '0;
    int               mismatch_count = 0;
    int               distances = 0;
    int               timestamps = 0;
    int               scan_ends = 0;
    int               error_words = 0;

    function logic [5:0] char_value(logic [7:0] c);
      logic [7:0] t;
      t = c - CH_ZERO;
      return t[5:0];
    endfunction

    function void push_word(logic [KIND_W-1:0] kind, logic [VAL_W-1:0] value,
                            logic [IDX_W-1:0] index);
      word_t w;
      w.kind  = kind;
      w.value = value;
      w.index = index;
      w.last  = 1'b0;
      expected_words.push_back(w);
    endfunction

    function void abort_scan(logic [VAL_W-1:0] code);
      push_word(KIND_ERR, code, '0);
      line_no = 0;
      carry_n = 0;
    endfunction

    function void take_data_char(logic [7:0] c);
      if (carry_n >= 2) begin
        push_word(KIND_DIST, {6'd0, char_value(carry_buf[0]), char_value(carry_buf[1]),
                              char_value(c)}, next_idx);
        if (next_idx != IDX_MAX) next_idx++;
        carry_n = 0;
      end else begin
        carry_buf[carry_n] = c;
        carry_n++;
      end
    endfunction

    function void close_line();
      int unsigned      len;
      int unsigned      num;
      int unsigned      sum;
      int unsigned      nd;
      logic [VAL_W-1:0] ts;
      bit               marker;
      len = line_len;
      num = line_no;
      line_len = 0;
      if (num > 3 && len >= 3) begin
        sum = 0;
        for (int i = 0; i + 1 < len; i++) sum += line_buf[i];
        if (((sum & 32'h3f) + 32'h30) != line_buf[len-1]) begin
          abort_scan(ERR_CHECKSUM);
          return;
        end
      end
      if (num >= 6 && len == 0) begin
        push_word(KIND_END, '0, '0);
        line_no = 0;
        carry_n = 0;
        return;
      end
      if (num == 0) begin
        if (len >= 1 && (line_buf[0] == CH_M || line_buf[0] == CH_G)) begin
          echo_g   = (line_buf[0] == CH_G);
          carry_n  = 0;
          next_idx = first_step;
          line_no  = 1;
        end else begin
          abort_scan(ERR_ECHO);
        end
        return;
      end
      marker = len >= 3 && line_buf[0] == CH_NINE && line_buf[1] == CH_NINE &&
               line_buf[2] == CH_B;
      if (num <= 4 && marker) begin
        line_no = 5;
      end else if (num == 1 && echo_g) begin
        line_no = 5;
      end else if (num == 4) begin
        abort_scan(ERR_MARKER);
      end else if (num == 5) begin
        ts = '0;
        for (int i = 0; i < 4; i++)
          ts = {ts[VAL_W-7:0], (i < len) ? char_value(line_buf[i]) : 6'd0};
        push_word(KIND_TIME, ts, '0);
        line_no = 6;
      end else if (num >= 6) begin
        nd = len - 1;
        if (nd > DATA_LIMIT) nd = DATA_LIMIT;
        for (int i = 0; i < nd; i++) take_data_char(line_buf[i]);
        line_no = 6;
      end else begin
        line_no = num + 1;
      end
    endfunction

    function void note_byte(logic [7:0] b);
      int    first;
      word_t w;
      first = expected_words.size();
      if (b == CH_CR || b == CH_LF) begin
        close_line();
      end else begin
        if (line_len < LINE_CAP) line_buf[line_len] = b;
        line_len++;
        if (line_len >= LINE_CAP - 1) close_line();
      end
      if (expected_words.size() > first) begin
        w = expected_words.pop_back();
        w.last = 1'b1;
        expected_words.push_back(w);
      end
    endfunction

    task report(string msg);
      mismatch_count++;
      if (mismatch_count <= 40) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_word(logic [KIND_W-1:0] kind, logic [VAL_W-1:0] value,
                    logic [IDX_W-1:0] index, logic last);
      word_t w;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word kind %0d value %h index %0d last %b",
                         kind, value, index, last));
        return;
      end
      w = expected_words.pop_front();
      case (w.kind)
        KIND_DIST: distances++;
        KIND_TIME: timestamps++;
        KIND_END:  scan_ends++;
        default:   error_words++;
      endcase
      if (kind !== w.kind || value !== w.value || index !== w.index || last !== w.last)
        report($sformatf("got kind %0d value %h index %0d last %b, wanted %0d %h %0d %b",
                         kind, value, index, last, w.kind, w.value, w.index, w.last));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = 8'h00;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [TDATA_W-1:0]  out_tdata;
  logic [KIND_W-1:0]   out_tuser;
  logic                out_tlast;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = 3'd0;
  logic [31:0]         pwdata = 32'd0;
  logic [31:0]         prdata;
  logic                pready;

  scan_scoreboard scan_sb;
  char_q_t        stream;
  bit             no_idle = 1'b0;
  bit             hold_request = 1'b0;
  int             idle_cycles = 0;
  int             in_words = 0;
  int             settings = 0;

  scip_scan_response_decoder_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      scan_sb.check_word(out_tuser, out_tdata[VAL_W-1:0], out_tdata[VAL_W+IDX_W-1:VAL_W],
                         out_tlast);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : result_sink
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  function automatic char_q_t text(string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [7:0] rand_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(8'h30, 8'h6f));
    do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF);
    return c;
  endfunction

  function automatic char_q_t rand_body(int n);
    char_q_t q;
    repeat (n) q.push_back(rand_char());
    return q;
  endfunction

  function automatic logic [7:0] check_char(char_q_t body);
    int unsigned sum;
    sum = 0;
    foreach (body[i]) sum += body[i];
    return 8'((sum & 32'h3f) + 32'h30);
  endfunction

  function automatic void add_line(char_q_t body, bit checked, bit corrupt);
    logic [7:0] ck;
    ck = check_char(body);
    foreach (body[i]) stream.push_back(body[i]);
    if (checked) stream.push_back(corrupt ? ck ^ 8'h01 : ck);
    stream.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
  endfunction

  function automatic void add_noise();
    repeat ($urandom_range(1, 16))
      stream.push_back(($urandom_range(0, 5) == 0) ? CH_LF : 8'($urandom_range(0, 255)));
    // Enough empty lines to bring the decoder back to idle from any line.
    repeat (7) stream.push_back(CH_LF);
  endfunction

  function automatic void add_scan(fault_t fault, int long_lines);
    char_q_t    body;
    logic [7:0] c;
    bit         g;
    int         early;
    int         n_data;
    int         bad_line;
    int         len;
    g = (fault == FAULT_MARKER) ? 1'b0 : 1'($urandom_range(0, 1));
    body = rand_body($urandom_range(0, 6));
    c = g ? CH_G : CH_M;
    if (fault == FAULT_ECHO) begin
      do c = rand_char(); while (c == CH_M || c == CH_G);
    end
    body.push_front(c);
    add_line(body, 1'b0, 1'b0);
    if (fault == FAULT_ECHO) return;
    if (g) begin
      add_line(rand_body($urandom_range(0, 4)), 1'b0, 1'b0);
    end else begin
      early = (fault == FAULT_MARKER) ? 4 : $urandom_range(1, 4);
      repeat (early - 1) add_line(rand_body($urandom_range(0, 5)), 1'b0, 1'b0);
      if (fault == FAULT_MARKER) body = text("abc");
      else body = text("99b");
      repeat ($urandom_range(0, 3)) body.push_back(rand_char());
      add_line(body, early == 4, 1'b0);
      if (fault == FAULT_MARKER) return;
    end
    n_data = $urandom_range(1, 3) + long_lines;
    bad_line = (fault == FAULT_SUM) ? $urandom_range(0, n_data) : -1;
    if (bad_line != 0 && $urandom_range(0, 5) == 0)
      add_line(rand_body($urandom_range(0, 2)), 1'b0, 1'b0);
    else
      add_line(rand_body(4), 1'b1, bad_line == 0);
    if (bad_line == 0) return;
    for (int d = 1; d <= n_data; d++) begin
      len = (d <= long_lines) ? $urandom_range(60, 125) : $urandom_range(1, 30);
      if (d == bad_line && len < 2) len = 2;
      add_line(rand_body(len), 1'b1, d == bad_line);
      if (d == bad_line) return;
    end
    stream.push_back(CH_LF);
  endfunction

  task automatic send_stream();
    logic [7:0] b;
    while (stream.size() > 0) begin
      b = stream.pop_front();
      if (!no_idle && $urandom_range(0, 4) == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= b;
      do @(posedge clk); while (!in_tready);
      scan_sb.note_byte(b);
      in_words++;
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    while (scan_sb.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_first_step(input logic [IDX_W-1:0] v);
    logic [31:0] rd;
    apb_access(1'b1, REG_FIRST_STEP, 32'(v), rd);
    scan_sb.first_step = v;
    settings++;
    apb_access(1'b0, REG_FIRST_STEP, 32'd0, rd);
    if (rd[IDX_W-1:0] !== v)
      scan_sb.report($sformatf("first_step reads %0d after writing %0d", rd[IDX_W-1:0], v));
  endtask

  initial begin : stimulus
    logic [31:0] rd;
    char_q_t     body;
    int          random_bytes;
    scan_sb = new();
    random_bytes = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    apb_access(1'b0, REG_FIRST_STEP, 32'd0, rd);
    if (rd[IDX_W-1:0] !== '0) scan_sb.report("first_step is not zero after reset");

    // Bad and empty echo lines, then a full M scan with an empty status line,
    // extreme characters and a triple split over two data lines.
    add_line(text("X"), 1'b0, 1'b0);
    stream.push_back(CH_LF);
    add_line(text("MD0000"), 1'b0, 1'b0);
    add_line(text("00P"), 1'b0, 1'b0);
    add_line(text(""), 1'b0, 1'b0);
    add_line(text("a"), 1'b0, 1'b0);
    add_line(text("99b"), 1'b1, 1'b0);
    add_line(text("oooo"), 1'b1, 1'b0);
    add_line(text("ooo000"), 1'b1, 1'b0);
    body.push_back(8'h00);
    body.push_back(8'hff);
    body.push_back(8'h80);
    add_line(body, 1'b1, 1'b0);
    add_line(text("00"), 1'b1, 1'b0);
    add_line(text("o"), 1'b1, 1'b0);
    stream.push_back(CH_CR);
    // G echo with a short timestamp, an early marker, then a bad checksum
    // and a missing marker.
    add_line(text("GD"), 1'b0, 1'b0);
    add_line(text("xx"), 1'b0, 1'b0);
    add_line(text("1"), 1'b0, 1'b0);
    add_line(text("123"), 1'b1, 1'b0);
    stream.push_back(CH_LF);
    add_line(text("M"), 1'b0, 1'b0);
    add_line(text("99b"), 1'b0, 1'b0);
    add_line(text("0000"), 1'b1, 1'b1);
    add_line(text("M"), 1'b0, 1'b0);
    add_line(text("s1"), 1'b0, 1'b0);
    add_line(text("s2"), 1'b0, 1'b0);
    add_line(text("s3"), 1'b0, 1'b0);
    add_line(text("abc"), 1'b1, 1'b0);
    send_stream();
    settle();

    // A data line that fills the line store closes by itself; the index
    // saturates, and the following line end is an empty line. The receiver
    // holds off meanwhile, so the decoder stalls its input.
    set_first_step(11'd2040);
    add_line(text("G"), 1'b0, 1'b0);
    add_line(text(""), 1'b0, 1'b0);
    add_line(rand_body(4), 1'b1, 1'b0);
    body = rand_body(LINE_CAP - 2);
    body.push_back(check_char(body));
    foreach (body[i]) stream.push_back(body[i]);
    stream.push_back(CH_LF);
    hold_request = 1'b1;
    send_stream();
    settle();

    while (random_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 1) == 0) set_first_step(11'($urandom_range(0, 2047)));
      case ($urandom_range(0, 9))
        0:       add_noise();
        1:       add_scan(FAULT_ECHO, 0);
        2:       add_scan(FAULT_MARKER, 0);
        3:       add_scan(FAULT_SUM, $urandom_range(0, 1));
        default: add_scan(FAULT_NONE, ($urandom_range(0, 4) == 0) ? 1 : 0);
      endcase
      random_bytes += stream.size();
      send_stream();
      settle();
    end

    no_idle = 1'b1;
    set_first_step(IDX_MAX);
    add_scan(FAULT_NONE, 0);
    send_stream();
    settle();

    if (scan_sb.expected_words.size() != 0)
      scan_sb.report($sformatf("%0d expected words never arrived",
                               scan_sb.expected_words.size()));
    $display("tb: %0d characters sent under %0d first_step settings", in_words, settings);
    $display("tb: %0d distances, %0d timestamps, %0d scan ends and %0d errors checked",
             scan_sb.distances, scan_sb.timestamps, scan_sb.scan_ends, scan_sb.error_words);
    if (scan_sb.mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
